### hw/rtl/bti_pkg.sv
// ----------------------------------------------------------------------------
// BSSID table package
// Shared constants, types and field helpers for the BSSID table block.
// ----------------------------------------------------------------------------
package bti_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Fixed field widths of the request and response.
   localparam int KEY_W    = 48;
   localparam int SLOT_W   = 6;
   localparam int OCC_W    = 7;
   localparam int TOTAL_W  = 32;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_UPDATED  = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One network report.
   typedef struct packed {
      logic [KEY_W-1:0]   bssid;
      logic signed [7:0]  signal_dbm;
      logic [7:0]         radio_channel;
      logic [2:0]         security_kind;
      logic               hidden_flag;
      logic [15:0]        frames_seen;
      logic [31:0]        now_tick;
   } req_type;

   // Per-slot record, everything but the key.
   typedef struct packed {
      logic [7:0]  signal_dbm;
      logic [7:0]  radio_channel;
      logic [2:0]  security_kind;
      logic        hidden_flag;
      logic [31:0] first_tick;
      logic [31:0] latest_tick;
      logic [31:0] beacon;
   } rec_type;

   // One result.
   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [TOTAL_W-1:0]  beacon_total;
      logic [TOTAL_W-1:0]  first_tick;
      logic [OCC_W-1:0]    occupied;
      logic [TOTAL_W-1:0]  found_total;
      logic [TOTAL_W-1:0]  hidden_total;
   } res_type;

   // Handshake between the engine and the output stage.
   typedef struct packed {
      logic idle;
      logic res_vld;
   } eng_stat_type;

   // Slot index to the fixed response width (low bits kept).
   function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

   // Entry count to the fixed response width (low bits kept).
   function automatic logic [OCC_W-1:0] occ_field(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[OCC_W-1:0];
   endfunction

endpackage

### hw/rtl/bti_req_if.sv
// ----------------------------------------------------------------------------
// BSSID table request channel
// Valid/ready channel that carries one network report.
// ----------------------------------------------------------------------------
interface bti_req_if;
   logic               valid;
   logic               ready;
   logic [47:0]        bssid;
   logic signed [7:0]  signal_dbm;
   logic [7:0]         radio_channel;
   logic [2:0]         security_kind;
   logic               hidden_flag;
   logic [15:0]        frames_seen;
   logic [31:0]        now_tick;

   modport source (
      output valid, bssid, signal_dbm, radio_channel, security_kind, hidden_flag,
             frames_seen, now_tick,
      input  ready
   );

   modport sink (
      input  valid, bssid, signal_dbm, radio_channel, security_kind, hidden_flag,
             frames_seen, now_tick,
      output ready
   );
endinterface

### hw/rtl/bti_rsp_if.sv
// ----------------------------------------------------------------------------
// BSSID table response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface bti_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  slot;
   logic [31:0] beacon_total;
   logic [31:0] first_tick;
   logic [6:0]  occupied;
   logic [31:0] found_total;
   logic [31:0] hidden_total;

   modport source (
      output valid, status, slot, beacon_total, first_tick, occupied,
             found_total, hidden_total,
      input  ready
   );

   modport sink (
      input  valid, status, slot, beacon_total, first_tick, occupied,
             found_total, hidden_total,
      output ready
   );
endinterface

### hw/rtl/bti_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bti_engine.sv
// ----------------------------------------------------------------------------
// BSSID table search and update engine
// Scans occupied slots through the key memory, then updates, appends or reports full.
// ----------------------------------------------------------------------------
module bti_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bti_pkg::req_type        req,
   input  logic                    res_take,
   output bti_pkg::eng_stat_type   stat,
   output bti_pkg::res_type        res
);

   bti_pkg::state_type             state_ff, state_in;
   bti_pkg::req_type               req_ff, req_in;
   bti_pkg::res_type               res_ff, res_in;
   logic [bti_pkg::CNT_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [bti_pkg::IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [bti_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [31:0]                    found_ff, found_in;
   logic [31:0]                    hidden_ff, hidden_in;

   logic                           key_we;
   logic                           rec_we;
   logic [bti_pkg::IDX_W-1:0]      wr_addr;
   logic [bti_pkg::IDX_W-1:0]      rd_addr;
   logic [bti_pkg::KEY_W-1:0]      key_rd;
   bti_pkg::rec_type               rec_rd;
   bti_pkg::rec_type               rec_wr;
   logic                           match;
   logic [31:0]                    beacon_sum;

   // Key and record memories share one read address.
   bti_ram #(
      .WIDTH (bti_pkg::KEY_W),
      .DEPTH (bti_pkg::TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (req_ff.bssid),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   bti_ram #(
      .WIDTH ($bits(bti_pkg::rec_type)),
      .DEPTH (bti_pkg::TABLE_ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (wr_addr),
      .wr_data (rec_wr),
      .rd_addr (rd_addr),
      .rd_data (rec_rd)
   );

   assign rd_addr    = issue_idx_ff[bti_pkg::IDX_W-1:0];
   assign match      = cmp_vld_ff && (key_rd == req_ff.bssid);
   assign beacon_sum = rec_rd.beacon + 32'(req_ff.frames_seen);

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bti_pkg::ST_IDLE;
         cmp_vld_ff <= 1'b0;
         count_ff  <= '0;
         found_ff  <= '0;
         hidden_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         hidden_ff <= hidden_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
   end

   // Sequencer: the scan issues one read per cycle and compares the key
   // read in the previous cycle, so a match is seen in the cycle after issue.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      issue_idx_in = issue_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      hidden_in    = hidden_ff;
      key_we       = 1'b0;
      rec_we       = 1'b0;
      wr_addr      = cmp_idx_ff;
      rec_wr       = rec_rd;
      stat.idle    = 1'b0;
      stat.res_vld = 1'b0;

      unique case (state_ff)
         bti_pkg::ST_IDLE: begin
            stat.idle = 1'b1;
            if (start) begin
               req_in       = req;
               issue_idx_in = '0;
               cmp_vld_in   = 1'b0;
               state_in     = bti_pkg::ST_SCAN;
            end
         end

         bti_pkg::ST_SCAN: begin
            if (match) begin
               // Update the matching entry in place.
               rec_we               = 1'b1;
               wr_addr              = cmp_idx_ff;
               rec_wr               = rec_rd;
               rec_wr.signal_dbm    = req_ff.signal_dbm;
               rec_wr.radio_channel = req_ff.radio_channel;
               rec_wr.latest_tick   = req_ff.now_tick;
               rec_wr.beacon        = beacon_sum;
               res_in.status          = bti_pkg::STATUS_UPDATED;
               res_in.slot            = bti_pkg::slot_field(cmp_idx_ff);
               res_in.beacon_total    = beacon_sum;
               res_in.first_tick      = rec_rd.first_tick;
               res_in.occupied        = bti_pkg::occ_field(count_ff);
               res_in.found_total     = found_ff;
               res_in.hidden_total    = hidden_ff;
               cmp_vld_in             = 1'b0;
               state_in               = bti_pkg::ST_DONE;
            end else if (issue_idx_ff == count_ff) begin
               cmp_vld_in = 1'b0;
               state_in   = bti_pkg::ST_DONE;
               if (count_ff == bti_pkg::CNT_W'(bti_pkg::TABLE_ENTRIES)) begin
                  // No match and no free slot: the request is dropped.
                  res_in.status          = bti_pkg::STATUS_FULL;
                  res_in.slot            = '0;
                  res_in.beacon_total    = '0;
                  res_in.first_tick      = '0;
                  res_in.occupied        = bti_pkg::occ_field(count_ff);
                  res_in.found_total     = found_ff;
                  res_in.hidden_total    = hidden_ff;
               end else begin
                  // Append a new entry at the first free slot.
                  key_we               = 1'b1;
                  rec_we               = 1'b1;
                  wr_addr              = count_ff[bti_pkg::IDX_W-1:0];
                  rec_wr.signal_dbm    = req_ff.signal_dbm;
                  rec_wr.radio_channel = req_ff.radio_channel;
                  rec_wr.security_kind = req_ff.security_kind;
                  rec_wr.hidden_flag   = req_ff.hidden_flag;
                  rec_wr.first_tick    = req_ff.now_tick;
                  rec_wr.latest_tick   = req_ff.now_tick;
                  rec_wr.beacon        = 32'(req_ff.frames_seen);
                  count_in  = count_ff + bti_pkg::CNT_W'(1);
                  found_in  = found_ff + 32'd1;
                  hidden_in = hidden_ff + 32'(req_ff.hidden_flag);
                  res_in.status          = bti_pkg::STATUS_INSERTED;
                  res_in.slot            = bti_pkg::slot_field(count_ff[bti_pkg::IDX_W-1:0]);
                  res_in.beacon_total    = 32'(req_ff.frames_seen);
                  res_in.first_tick      = req_ff.now_tick;
                  res_in.occupied        = bti_pkg::occ_field(count_in);
                  res_in.found_total     = found_in;
                  res_in.hidden_total    = hidden_in;
               end
            end else begin
               // Issue the next slot read.
               issue_idx_in = issue_idx_ff + bti_pkg::CNT_W'(1);
               cmp_vld_in   = 1'b1;
               cmp_idx_in   = issue_idx_ff[bti_pkg::IDX_W-1:0];
            end
         end

         bti_pkg::ST_DONE: begin
            stat.res_vld = 1'b1;
            if (res_take) begin
               state_in = bti_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bti_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

`ifndef ASSERT_OFF
   // The entry count never goes past the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bti_pkg::CNT_W'(bti_pkg::TABLE_ENTRIES))
      else $error("entry count exceeds table size");

   // The scan never issues past the occupied slots.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bti_pkg::ST_SCAN) |-> (issue_idx_ff <= count_ff))
      else $error("scan index past occupied slots");

   // Memory writes happen only at the decision point of a scan.
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (key_we || rec_we) |-> (state_ff == bti_pkg::ST_SCAN))
      else $error("memory write outside scan");

   // A key write is always an append, which grows the table by one.
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      key_we |=> (count_ff == $past(count_ff) + bti_pkg::CNT_W'(1)))
      else $error("append without count increment");

   // A compare result is only pending while scanning.
   a_cmp_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == bti_pkg::ST_SCAN))
      else $error("compare pending outside scan");
`endif

endmodule

### hw/rtl/bssid_table_insert_or_update_core.sv
// One request is handled at a time: a new request is accepted only while the
// engine is idle. The scan reads one slot per cycle through the single read
// port of the key memory.
// Reset clears the entry count and both counters; table memories are not
// cleared and need no clearing pass, since only occupied slots are read.
// ----------------------------------------------------------------------------
// BSSID table insert or update
// Looks up a reported BSSID, updates its entry, appends one or reports a full
// table, and returns status, slot, totals and counters via an output register.
// ----------------------------------------------------------------------------
module bssid_table_insert_or_update_core (
   input  logic       clock,
   input  logic       reset,
   bti_req_if.sink    req_chan,
   bti_rsp_if.source  rsp_chan
);

   bti_pkg::req_type       req;
   bti_pkg::res_type       res;
   bti_pkg::eng_stat_type  stat;
   logic                   start;
   logic                   res_take;
   logic                   rsp_vld_ff, rsp_vld_in;
   bti_pkg::res_type       rsp_ff, rsp_in;

   // Gather the request fields.
   assign req.bssid         = req_chan.bssid;
   assign req.signal_dbm    = req_chan.signal_dbm;
   assign req.radio_channel = req_chan.radio_channel;
   assign req.security_kind = req_chan.security_kind;
   assign req.hidden_flag   = req_chan.hidden_flag;
   assign req.frames_seen   = req_chan.frames_seen;
   assign req.now_tick      = req_chan.now_tick;

   assign req_chan.ready = stat.idle;
   assign start          = req_chan.valid && stat.idle;

   bti_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .res_take (res_take),
      .stat     (stat),
      .res      (res)
   );

   // Output register: takes a finished result when empty or being drained.
   assign res_take   = stat.res_vld && (!rsp_vld_ff || rsp_chan.ready);
   assign rsp_vld_in = res_take || (rsp_vld_ff && !rsp_chan.ready);
   assign rsp_in     = res_take ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Drive the response channel.
   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.slot            = rsp_ff.slot;
   assign rsp_chan.beacon_total    = rsp_ff.beacon_total;
   assign rsp_chan.first_tick      = rsp_ff.first_tick;
   assign rsp_chan.occupied        = rsp_ff.occupied;
   assign rsp_chan.found_total     = rsp_ff.found_total;
   assign rsp_chan.hidden_total    = rsp_ff.hidden_total;

`ifndef ASSERT_OFF
   // A new request is never taken while the engine still holds a result.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      start |-> !stat.res_vld)
      else $error("request accepted while result pending");

   // A result moves into the output register only when there is room.
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      res_take |-> (!rsp_vld_ff || rsp_chan.ready))
      else $error("output register overwritten");

   // After an accepted request the engine is busy on the next cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      start |=> !stat.idle)
      else $error("engine idle after accepting a request");
`endif

endmodule
